// ----- hdl/intel_hex_record_writer_macros.svh -----
// ----------------------------------------------------------------------------
// Intel HEX record writer assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_WRITER_MACROS_SVH
`define INTEL_HEX_RECORD_WRITER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define IHW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IHW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ihw_pkg.sv -----
// ----------------------------------------------------------------------------
// Intel HEX record writer package
// Shared sizes, character and record-type codes, descriptor types.
// ----------------------------------------------------------------------------
package ihw_pkg;

    // data bytes per record and derived widths
    localparam int RECORD_BYTES = 16;
    localparam int IDX_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CNT_W        = $clog2(RECORD_BYTES + 1);
    localparam int REC_CNT_W    = (CNT_W > 2) ? CNT_W : 2;
    localparam int BANKS        = 2;
    localparam int RAM_AW       = IDX_W + 1;
    localparam int RAM_DEPTH    = BANKS << IDX_W;
    localparam int DESC_DEPTH   = 2;

    // characters
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A_OFS = 8'h37;

    // record types
    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_EXT  = 8'h04;

    // payload length of an extended linear address record
    localparam logic [REC_CNT_W-1:0] EXT_LEN = REC_CNT_W'(2);

    // header byte positions
    localparam logic [1:0] HDR_COUNT   = 2'd0;
    localparam logic [1:0] HDR_ADDR_HI = 2'd1;
    localparam logic [1:0] HDR_ADDR_LO = 2'd2;
    localparam logic [1:0] HDR_TYPE    = 2'd3;

    typedef enum logic [1:0] {
        REC_DATA,
        REC_EXT,
        REC_EOF
    } rec_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLON,
        S_HDR,
        S_FETCH,
        S_PAY,
        S_SUM,
        S_LF
    } back_state_t;

    // all records caused by one input byte
    typedef struct packed {
        logic             pre;
        logic [CNT_W-1:0] pre_count;
        logic [15:0]      pre_start;
        logic             pre_bank;
        logic             ext;
        logic [15:0]      ext_hi;
        logic             data;
        logic [CNT_W-1:0] data_count;
        logic [15:0]      data_start;
        logic             data_bank;
        logic             eof;
    } desc_t;

    // records of the current descriptor still to emit
    typedef struct packed {
        logic pre;
        logic ext;
        logic data;
        logic eof;
    } pend_t;

    // back end hands a buffer bank back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    // front end status
    typedef struct packed {
        logic [BANKS-1:0] busy;
    } front_status_t;

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] wide;
        wide = {4'h0, v};
        return (v < 4'd10) ? (CHAR_ZERO + wide) : (CHAR_A_OFS + wide);
    endfunction

endpackage

// ----- hdl/intel_hex_record_writer.sv -----
// Intel HEX record writer. Image bytes enter on the s_ side (tlast on the
// final byte); Intel HEX text leaves on the m_ side one ASCII character per
// transfer, each line ending in LF, with tlast on the last character that an
// input byte causes. A byte that causes no record is written to the record
// buffer but queues no descriptor. The back end sends at most one character
// per cycle and holds it while the output is stalled; it reads each data
// byte from the registered record buffer before it sends its two characters.
// The descriptor queue holds two entries and the record buffer has two
// banks, so the front end keeps filling one bank while the back end prints
// the other.
`include "intel_hex_record_writer_macros.svh"

// ----------------------------------------------------------------------------
// Intel HEX record writer top level
// Front end, descriptor queue, record buffer and text back end.
// ----------------------------------------------------------------------------
module intel_hex_record_writer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] ascii_char
    output logic       m_tlast    // last_of_run
);

    ihw_pkg::desc_t                push_desc;
    ihw_pkg::desc_t                pop_desc;
    logic                          push;
    logic                          pop;
    logic                          fifo_full;
    logic                          fifo_empty;
    logic                          wr_en;
    logic [ihw_pkg::RAM_AW-1:0]    wr_addr;
    logic [7:0]                    wr_data;
    logic [ihw_pkg::RAM_AW-1:0]    rd_addr;
    logic [7:0]                    rd_data;
    ihw_pkg::release_t             rel;
    ihw_pkg::front_status_t        front_status;

    // byte intake and classification
    ihw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .desc      (push_desc),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rel       (rel),
        .status    (front_status)
    );

    // descriptor queue
    ihw_desc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (push_desc),
        .full    (fifo_full),
        .pop     (pop),
        .rd_desc (pop_desc),
        .empty   (fifo_empty)
    );

    // two-bank record buffer
    ihw_ram #(
        .WIDTH (8),
        .DEPTH (ihw_pkg::RAM_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // record text generation
    ihw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_in    (pop_desc),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rel        (rel),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

    // checks
    `IHW_ASSERT_NOW(a_no_write_busy_bank, wr_en, !front_status.busy[wr_addr[ihw_pkg::RAM_AW-1]], "buffer write into a bank still being printed")
    `IHW_ASSERT_NOW(a_release_busy_bank, rel.valid, front_status.busy[rel.bank], "release of a bank that was not busy")
    `IHW_ASSERT_NOW(a_run_ends_on_lf, m_tvalid && m_tlast, m_tdata == ihw_pkg::CHAR_LF, "end of run on a character other than LF")
    `IHW_ASSERT_NEXT(a_push_fills_queue, push && !pop, !fifo_empty, "queue empty after a descriptor was pushed")

endmodule

// ----- hdl/ihw_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ihw_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/ihw_desc_fifo.sv -----
// ----------------------------------------------------------------------------
// Descriptor queue
// Two-entry queue of record descriptors between front and back end.
// ----------------------------------------------------------------------------
module ihw_desc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ihw_pkg::desc_t wr_desc,
    output logic           full,
    input  logic           pop,
    output ihw_pkg::desc_t rd_desc,
    output logic           empty
);

    localparam int PTR_W = $clog2(ihw_pkg::DESC_DEPTH);
    localparam int LVL_W = $clog2(ihw_pkg::DESC_DEPTH + 1);

    ihw_pkg::desc_t   entry_reg [ihw_pkg::DESC_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push, do_pop;

    assign full    = (level_reg == LVL_W'(ihw_pkg::DESC_DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_desc = entry_reg[rd_ptr_reg];

    // pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ihw_pkg::DESC_DEPTH - 1)) ? '0
                        : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ihw_pkg::DESC_DEPTH - 1)) ? '0
                        : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            level_next = LVL_W'(level_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = LVL_W'(level_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

// ----- hdl/ihw_front.sv -----
// ----------------------------------------------------------------------------
// Intel HEX front end
// Accepts image bytes, buffers them in two banks, tracks the address and
// queues one descriptor per byte that causes records.
// ----------------------------------------------------------------------------
module ihw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    input  logic                          fifo_full,
    output logic                          push,
    output ihw_pkg::desc_t                desc,
    output logic                          wr_en,
    output logic [ihw_pkg::RAM_AW-1:0]    wr_addr,
    output logic [7:0]                    wr_data,
    input  ihw_pkg::release_t             rel,
    output ihw_pkg::front_status_t        status
);

    localparam int CNT_W = ihw_pkg::CNT_W;
    localparam int IDX_W = ihw_pkg::IDX_W;

    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [31:0]               addr_reg, addr_next;
    logic                      wbank_reg, wbank_next;
    logic [ihw_pkg::BANKS-1:0] busy_reg, busy_next;

    logic                      accept;
    logic                      seg_start;
    logic                      pre;
    logic                      tbank;
    logic [CNT_W-1:0]          wfill;
    logic [CNT_W-1:0]          nfill;
    logic                      post;
    logic [15:0]               next_lo;

    // classify the offered byte
    always_comb
    begin
        seg_start = (addr_reg[15:0] == 16'h0000);
        pre       = seg_start && (fill_reg != '0);
        tbank     = pre ? !wbank_reg : wbank_reg;
        wfill     = pre ? '0 : fill_reg;
        nfill     = CNT_W'(wfill + 1'b1);
        post      = (nfill == CNT_W'(ihw_pkg::RECORD_BYTES)) || in_last;
        next_lo   = 16'(addr_reg[15:0] + 16'd1);
    end

    assign in_ready = !fifo_full && !busy_reg[tbank];
    assign accept   = in_valid && in_ready;

    // buffer write
    assign wr_en   = accept;
    assign wr_addr = {tbank, wfill[IDX_W-1:0]};
    assign wr_data = in_byte;

    // descriptor
    always_comb
    begin
        desc.pre        = pre;
        desc.pre_count  = fill_reg;
        desc.pre_start  = 16'(addr_reg[15:0] - 16'(fill_reg));
        desc.pre_bank   = wbank_reg;
        desc.ext        = seg_start;
        desc.ext_hi     = addr_reg[31:16];
        desc.data       = post;
        desc.data_count = nfill;
        desc.data_start = 16'(next_lo - 16'(nfill));
        desc.data_bank  = tbank;
        desc.eof        = in_last;
    end

    assign push = accept && (seg_start || post);

    // counter, address and bank bookkeeping
    always_comb
    begin
        fill_next  = fill_reg;
        addr_next  = addr_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            fill_next  = post ? '0 : nfill;
            wbank_next = post ? !tbank : tbank;
            addr_next  = in_last ? 32'h0 : 32'(addr_reg + 32'd1);
            if (pre)
            begin
                busy_next[wbank_reg] = 1'b1;
            end
            if (post)
            begin
                busy_next[tbank] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            addr_reg  <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            addr_reg  <= addr_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    assign status.busy = busy_reg;

endmodule

// ----- hdl/ihw_back.sv -----
// ----------------------------------------------------------------------------
// Intel HEX back end
// Turns queued descriptors into record text, at most one character per
// cycle while the output is not stalled, behind an output register.
// ----------------------------------------------------------------------------
module ihw_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ihw_pkg::desc_t             desc_in,
    input  logic                       fifo_empty,
    output logic                       pop,
    output logic [ihw_pkg::RAM_AW-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output ihw_pkg::release_t          rel,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_char,
    output logic                       out_last
);

    localparam int RCW   = ihw_pkg::REC_CNT_W;
    localparam int IDX_W = ihw_pkg::IDX_W;

    ihw_pkg::back_state_t state_reg, state_next;
    ihw_pkg::pend_t       pend_reg, pend_next;
    ihw_pkg::desc_t       d_reg, d_next;
    ihw_pkg::rec_kind_t   kind_reg, kind_next;
    logic [RCW-1:0]       count_reg, count_next;
    logic [15:0]          raddr_reg, raddr_next;
    logic                 bank_reg, bank_next;
    logic [1:0]           hdr_idx_reg, hdr_idx_next;
    logic [RCW-1:0]       pay_idx_reg, pay_idx_next;
    logic                 nib_lo_reg, nib_lo_next;
    logic [7:0]           sum_reg, sum_next;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_last_reg;

    logic                 adv;
    logic                 emit;
    logic [7:0]           emit_char;
    logic                 emit_last;
    logic [7:0]           hdr_byte;
    logic [7:0]           pay_byte;
    logic [7:0]           cur_byte;
    logic [3:0]           nib_val;
    logic [7:0]           type_code;
    logic                 pay_done;

    assign adv     = !out_valid_reg || out_ready;
    assign rd_addr = {bank_reg, pay_idx_reg[IDX_W-1:0]};

    // byte under conversion
    always_comb
    begin
        unique case (kind_reg)
            ihw_pkg::REC_DATA: type_code = ihw_pkg::TYPE_DATA;
            ihw_pkg::REC_EXT:  type_code = ihw_pkg::TYPE_EXT;
            ihw_pkg::REC_EOF:  type_code = ihw_pkg::TYPE_EOF;
            default:           type_code = ihw_pkg::TYPE_EOF;
        endcase
        unique case (hdr_idx_reg)
            ihw_pkg::HDR_COUNT:   hdr_byte = 8'(count_reg);
            ihw_pkg::HDR_ADDR_HI: hdr_byte = raddr_reg[15:8];
            ihw_pkg::HDR_ADDR_LO: hdr_byte = raddr_reg[7:0];
            ihw_pkg::HDR_TYPE:    hdr_byte = type_code;
            default:              hdr_byte = type_code;
        endcase
        if (kind_reg == ihw_pkg::REC_EXT)
        begin
            pay_byte = pay_idx_reg[0] ? d_reg.ext_hi[7:0] : d_reg.ext_hi[15:8];
        end
        else
        begin
            pay_byte = rd_data;
        end
        unique case (state_reg)
            ihw_pkg::S_HDR: cur_byte = hdr_byte;
            ihw_pkg::S_PAY: cur_byte = pay_byte;
            ihw_pkg::S_SUM: cur_byte = 8'(8'h00 - sum_reg);
            default:        cur_byte = pay_byte;
        endcase
        nib_val  = nib_lo_reg ? cur_byte[3:0] : cur_byte[7:4];
        pay_done = (RCW'(pay_idx_reg + 1'b1) == count_reg);
    end

    // record sequencer
    always_comb
    begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        d_next       = d_reg;
        kind_next    = kind_reg;
        count_next   = count_reg;
        raddr_next   = raddr_reg;
        bank_next    = bank_reg;
        hdr_idx_next = hdr_idx_reg;
        pay_idx_next = pay_idx_reg;
        nib_lo_next  = nib_lo_reg;
        sum_next     = sum_reg;
        emit         = 1'b0;
        emit_char    = ihw_pkg::hex_char(nib_val);
        emit_last    = 1'b0;
        pop          = 1'b0;
        rel          = '0;

        unique case (state_reg)
            ihw_pkg::S_IDLE:
            begin
                priority if (pend_reg.pre)
                begin
                    kind_next     = ihw_pkg::REC_DATA;
                    count_next    = RCW'(d_reg.pre_count);
                    raddr_next    = d_reg.pre_start;
                    bank_next     = d_reg.pre_bank;
                    pend_next.pre = 1'b0;
                    state_next    = ihw_pkg::S_COLON;
                end
                else if (pend_reg.ext)
                begin
                    kind_next     = ihw_pkg::REC_EXT;
                    count_next    = ihw_pkg::EXT_LEN;
                    raddr_next    = 16'h0000;
                    pend_next.ext = 1'b0;
                    state_next    = ihw_pkg::S_COLON;
                end
                else if (pend_reg.data)
                begin
                    kind_next      = ihw_pkg::REC_DATA;
                    count_next     = RCW'(d_reg.data_count);
                    raddr_next     = d_reg.data_start;
                    bank_next      = d_reg.data_bank;
                    pend_next.data = 1'b0;
                    state_next     = ihw_pkg::S_COLON;
                end
                else if (pend_reg.eof)
                begin
                    kind_next     = ihw_pkg::REC_EOF;
                    count_next    = '0;
                    raddr_next    = 16'h0000;
                    pend_next.eof = 1'b0;
                    state_next    = ihw_pkg::S_COLON;
                end
                else if (!fifo_empty)
                begin
                    pop            = 1'b1;
                    d_next         = desc_in;
                    pend_next.pre  = desc_in.pre;
                    pend_next.ext  = desc_in.ext;
                    pend_next.data = desc_in.data;
                    pend_next.eof  = desc_in.eof;
                end
            end
            ihw_pkg::S_COLON:
            begin
                if (adv)
                begin
                    emit         = 1'b1;
                    emit_char    = ihw_pkg::CHAR_COLON;
                    sum_next     = 8'h00;
                    hdr_idx_next = ihw_pkg::HDR_COUNT;
                    nib_lo_next  = 1'b0;
                    state_next   = ihw_pkg::S_HDR;
                end
            end
            ihw_pkg::S_HDR:
            begin
                if (adv)
                begin
                    emit        = 1'b1;
                    nib_lo_next = !nib_lo_reg;
                    if (nib_lo_reg)
                    begin
                        sum_next = 8'(sum_reg + cur_byte);
                        if (hdr_idx_reg == ihw_pkg::HDR_TYPE)
                        begin
                            pay_idx_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = ihw_pkg::S_SUM;
                            end
                            else if (kind_reg == ihw_pkg::REC_DATA)
                            begin
                                state_next = ihw_pkg::S_FETCH;
                            end
                            else
                            begin
                                state_next = ihw_pkg::S_PAY;
                            end
                        end
                        else
                        begin
                            hdr_idx_next = 2'(hdr_idx_reg + 1'b1);
                        end
                    end
                end
            end
            ihw_pkg::S_FETCH:
            begin
                // buffer read data arrives next cycle
                state_next = ihw_pkg::S_PAY;
            end
            ihw_pkg::S_PAY:
            begin
                if (adv)
                begin
                    emit        = 1'b1;
                    nib_lo_next = !nib_lo_reg;
                    if (nib_lo_reg)
                    begin
                        sum_next     = 8'(sum_reg + cur_byte);
                        pay_idx_next = RCW'(pay_idx_reg + 1'b1);
                        if (pay_done)
                        begin
                            state_next = ihw_pkg::S_SUM;
                        end
                        else if (kind_reg == ihw_pkg::REC_DATA)
                        begin
                            state_next = ihw_pkg::S_FETCH;
                        end
                    end
                end
            end
            ihw_pkg::S_SUM:
            begin
                if (adv)
                begin
                    emit        = 1'b1;
                    nib_lo_next = !nib_lo_reg;
                    if (nib_lo_reg)
                    begin
                        state_next = ihw_pkg::S_LF;
                    end
                end
            end
            ihw_pkg::S_LF:
            begin
                if (adv)
                begin
                    emit       = 1'b1;
                    emit_char  = ihw_pkg::CHAR_LF;
                    emit_last  = (pend_reg == '0);
                    rel.valid  = (kind_reg == ihw_pkg::REC_DATA);
                    rel.bank   = bank_reg;
                    state_next = ihw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ihw_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ihw_pkg::S_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // record and output payload
    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        kind_reg    <= kind_next;
        count_reg   <= count_next;
        raddr_reg   <= raddr_next;
        bank_reg    <= bank_next;
        hdr_idx_reg <= hdr_idx_next;
        pay_idx_reg <= pay_idx_next;
        nib_lo_reg  <= nib_lo_next;
        sum_reg     <= sum_next;
        if (emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule
